@@ hw/rtl/bdr_pkg.sv @@
package bdr_pkg;

  // Saturation limits of the formatter state.
  localparam int unsigned MAX_DEPTH   = 255;
  localparam int unsigned MAX_PENDING = 65535;

  // Most results one input transaction can cause (closing brace case).
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Character codes.
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [3:0] INDENT_RESET = 4'd2;

  // One source item as it travels through the input buffer.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } item_t;

  // One run-length result.
  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] cnt;
  } result_t;

  // Formatter state carried from item to item.
  typedef struct packed {
    logic [7:0]  depth;
    logic        line_head;
    logic [15:0] pending;
  } fmt_state_t;

  // Clamp a sum of space counts to the pending limit.
  function automatic logic [15:0] sat_pending(input logic [16:0] v);
    logic [16:0] lim;
    lim = 17'(MAX_PENDING);
    return (v > lim) ? lim[15:0] : v[15:0];
  endfunction

endpackage

@@ hw/rtl/bdr_in_skid.sv @@
module bdr_in_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bdr_pkg::item_t in_item,
  input  logic           pop,
  output logic           head_valid,
  output bdr_pkg::item_t head_item
);
  import bdr_pkg::*;

  item_t       buf_r [2];
  item_t       buf_nxt [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        do_pop;

  // Stall comes straight from the fill count, so it never waits on the consumer.
  assign in_stall   = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = buf_r[rd_ptr_r];
  assign push       = in_valid && !in_stall;
  assign do_pop     = pop && head_valid;

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(do_pop);
    buf_nxt    = buf_r;
    if (push) begin
      buf_nxt[wr_ptr_r] = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

@@ hw/rtl/bdr_step.sv @@
module bdr_step (
  input  bdr_pkg::fmt_state_t               st,
  input  bdr_pkg::item_t                    item,
  input  logic [3:0]                        indent_width,
  output bdr_pkg::fmt_state_t               st_nxt,
  output bdr_pkg::result_t                  res [bdr_pkg::MAX_RESULTS],
  output logic [bdr_pkg::RES_CNT_W-1:0]     res_n,
  output logic                              is_end
);
  import bdr_pkg::*;

  logic [7:0]           dep_sel;
  logic [11:0]          prod;
  logic [15:0]          ind;
  logic [RES_CNT_W-1:0] k;

  // A closing brace is indented at the reduced depth; everything else at the current one.
  always_comb begin
    is_end  = item.eot || (item.ch == CH_NUL);
    dep_sel = ((item.ch == CH_CLOSE) && (st.depth != 8'd0)) ? st.depth - 8'd1 : st.depth;
    prod    = 12'(dep_sel) * 12'(indent_width);
    ind     = sat_pending(17'(prod));
  end

  // Build the result list in order and the next state.
  always_comb begin
    st_nxt = st;
    k      = '0;
    for (int i = 0; i < int'(MAX_RESULTS); i++) begin
      res[i] = '{ch: CH_NUL, cnt: 16'd0};
    end

    if (is_end) begin
      // Flush pending spaces, or write a bare end marker, then return to reset.
      if (st.pending != 16'd0) begin
        res[k] = '{ch: CH_SP, cnt: st.pending};
      end else begin
        res[k] = '{ch: CH_NUL, cnt: 16'd0};
      end
      k                 = k + 1'b1;
      st_nxt.depth      = 8'd0;
      st_nxt.line_head  = 1'b1;
      st_nxt.pending    = 16'd0;
    end else if (item.ch == CH_OPEN) begin
      // Space before the brace, then the brace and a newline.
      if (st.pending != 16'd0) begin
        res[k] = '{ch: CH_SP, cnt: st.pending};
        k      = k + 1'b1;
      end else if (!st.line_head) begin
        res[k] = '{ch: CH_SP, cnt: 16'd1};
        k      = k + 1'b1;
      end
      res[k] = '{ch: CH_OPEN, cnt: 16'd1};
      k      = k + 1'b1;
      res[k] = '{ch: CH_NL, cnt: 16'd1};
      k      = k + 1'b1;
      if (st.depth < 8'(MAX_DEPTH)) begin
        st_nxt.depth = st.depth + 8'd1;
      end
      st_nxt.pending    = 16'd0;
      st_nxt.line_head  = 1'b1;
    end else if (item.ch == CH_CLOSE) begin
      // Closing brace goes on a line of its own at the reduced depth.
      if (st.pending != 16'd0) begin
        res[k] = '{ch: CH_SP, cnt: st.pending};
        k      = k + 1'b1;
      end
      if (!st.line_head) begin
        res[k] = '{ch: CH_NL, cnt: 16'd1};
        k      = k + 1'b1;
      end
      if (ind != 16'd0) begin
        res[k] = '{ch: CH_SP, cnt: ind};
        k      = k + 1'b1;
      end
      res[k] = '{ch: CH_CLOSE, cnt: 16'd1};
      k      = k + 1'b1;
      res[k] = '{ch: CH_NL, cnt: 16'd1};
      k      = k + 1'b1;
      st_nxt.depth      = dep_sel;
      st_nxt.pending    = 16'd0;
      st_nxt.line_head  = 1'b1;
    end else if (item.ch == CH_NL) begin
      // Trailing spaces are dropped at a newline.
      res[k] = '{ch: CH_NL, cnt: 16'd1};
      k      = k + 1'b1;
      st_nxt.pending    = 16'd0;
      st_nxt.line_head  = 1'b1;
    end else begin
      // Indentation joins the pending count at the first byte of a line.
      if (st.line_head) begin
        st_nxt.pending    = sat_pending(17'(st.pending) + 17'(ind));
        st_nxt.line_head  = 1'b0;
      end
      if (item.ch == CH_SP) begin
        st_nxt.pending = sat_pending(17'(st_nxt.pending) + 17'd1);
      end else begin
        if (st_nxt.pending != 16'd0) begin
          res[k] = '{ch: CH_SP, cnt: st_nxt.pending};
          k      = k + 1'b1;
        end
        res[k] = '{ch: item.ch, cnt: 16'd1};
        k      = k + 1'b1;
        st_nxt.pending = 16'd0;
      end
    end
    res_n = k;
  end

endmodule

@@ hw/rtl/brace_depth_reindenter.sv @@
// Brace-depth re-indenter. Source bytes enter on the in_ channel, one per
// transaction, and leave as run-length results (out_byte repeated
// out_repeat_count times) on the out_ channel. A byte is formatted from the
// head of the two-entry input buffer in the cycle it leaves the buffer, and its
// whole result list is loaded into a result register that shifts out one
// result per cycle while out_stall is low. Ordinary bytes give one result (two
// with pending spaces) and, with one result and no stall, sustain one
// transaction per cycle; a space gives none; a newline one; an opening brace
// two or three; a closing brace two to five. A byte holds the result register
// until its last result is taken, which sets the rate on brace-heavy text.
// out_last_of_run marks the final result of each input, out_text_done the
// final result of an end-of-text item. The user writes the indent width on the
// cfg_ port only while the block is idle (not enforced); cfg_ready is always high.
module brace_depth_reindenter (
  input  logic        clk,
  input  logic        rst_n,
  // Source byte channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [15:0] out_repeat_count,
  output logic        out_last_of_run,
  output logic        out_text_done,
  // Indent width register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_indent_width
);
  import bdr_pkg::*;

  logic [3:0]           indent_r, indent_nxt;
  fmt_state_t           st_r, st_nxt, st_step;
  result_t              res_r [MAX_RESULTS];
  result_t              res_nxt [MAX_RESULTS];
  result_t              res_step [MAX_RESULTS];
  logic [RES_CNT_W-1:0] rem_r, rem_nxt, res_n;
  logic                 eot_r, eot_nxt;
  logic                 step_end;
  logic                 head_valid;
  item_t                head_item;
  item_t                in_item;
  logic                 load;
  logic                 take;

  assign cfg_ready = 1'b1;
  assign in_item   = '{ch: in_byte, eot: in_end_of_text};

  // Input buffer decouples the source from the result register.
  bdr_in_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .pop        (load),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Formatting of the item at the head of the buffer.
  bdr_step u_step (
    .st           (st_r),
    .item         (head_item),
    .indent_width (indent_r),
    .st_nxt       (st_step),
    .res          (res_step),
    .res_n        (res_n),
    .is_end       (step_end)
  );

  // Output side shows the front of the result register.
  assign out_valid        = (rem_r != '0);
  assign out_byte         = res_r[0].ch;
  assign out_repeat_count = res_r[0].cnt;
  assign out_last_of_run  = (rem_r == RES_CNT_W'(1));
  assign out_text_done    = (rem_r == RES_CNT_W'(1)) && eot_r;

  assign take = out_valid && !out_stall;
  assign load = head_valid && ((rem_r == '0) || ((rem_r == RES_CNT_W'(1)) && !out_stall));

  // Next values of the control state and the result register.
  always_comb begin
    indent_nxt = (cfg_valid && cfg_ready) ? cfg_indent_width : indent_r;
    st_nxt     = load ? st_step : st_r;
    rem_nxt    = rem_r;
    eot_nxt    = eot_r;
    res_nxt    = res_r;
    if (load) begin
      rem_nxt = res_n;
      eot_nxt = step_end;
      res_nxt = res_step;
    end else if (take) begin
      rem_nxt = rem_r - 1'b1;
      for (int i = 0; i < int'(MAX_RESULTS) - 1; i++) begin
        res_nxt[i] = res_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_r <= INDENT_RESET;
      st_r     <= '{depth: 8'd0, line_head: 1'b1, pending: 16'd0};
      rem_r    <= '0;
      eot_r    <= 1'b0;
    end else begin
      indent_r <= indent_nxt;
      st_r     <= st_nxt;
      rem_r    <= rem_nxt;
      eot_r    <= eot_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

@@ hw/rtl/bdr_checker.sv @@
module bdr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [15:0] out_repeat_count,
  input logic        out_last_of_run,
  input logic        out_text_done
);
  import bdr_pkg::*;

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_repeat_count) && $stable(out_last_of_run) && $stable(out_text_done))
    else $error("stalled result changed");

  // End of text always closes the run of its item.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_last_of_run)
    else $error("text_done without last_of_run");

  // A zero count is only the bare end marker.
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_repeat_count == 16'd0) |-> out_text_done && (out_byte == CH_NUL))
    else $error("zero count outside end marker");

  // A brace is never the final result of its item: a newline follows.
  a_brace_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_byte == CH_OPEN) || (out_byte == CH_CLOSE)) |-> !out_last_of_run)
    else $error("brace not followed by newline");

endmodule

bind brace_depth_reindenter bdr_checker u_bdr_checker (.*);
